// ===== hdl/npcm_pkg.sv =====
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared constants, types and control structs for the nearest palette color
// matcher.
// ----------------------------------------------------------------------------
package npcm_pkg;

  localparam int unsigned PALETTE_DEPTH = 16;
  localparam int unsigned ADDR_W        = $clog2(PALETTE_DEPTH);
  localparam int unsigned SIZE_W        = 5;
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned COLOR_W       = 8;
  localparam int unsigned ENTRY_W       = 3 * COLOR_W;
  localparam int unsigned PROD_W        = 2 * COLOR_W;
  localparam int unsigned DIST_W        = 18;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  typedef enum logic {
    FUNC_WRITE    = 1'b0,
    FUNC_CLASSIFY = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic              start;
    logic              wr;
    logic              issue;
    logic [ADDR_W-1:0] addr;
    logic              publish;
  } npcm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
    logic out_busy;
  } npcm_status_t;

endpackage

// ===== hdl/npcm_in_if.sv =====
// ----------------------------------------------------------------------------
// npcm_in_if
// Input item channel: palette writes and pixels to classify.
// ----------------------------------------------------------------------------
interface npcm_in_if;
  logic                               valid;
  logic                               ready;
  logic                               func;
  logic [npcm_pkg::IDX_W-1:0]         entry_index;
  logic [npcm_pkg::COLOR_W-1:0]       red;
  logic [npcm_pkg::COLOR_W-1:0]       green;
  logic [npcm_pkg::COLOR_W-1:0]       blue;

  modport source (output valid, func, entry_index, red, green, blue, input ready);
  modport sink   (input valid, func, entry_index, red, green, blue, output ready);
endinterface

// ===== hdl/npcm_out_if.sv =====
// ----------------------------------------------------------------------------
// npcm_out_if
// Result item channel: winning palette index and its squared distance.
// ----------------------------------------------------------------------------
interface npcm_out_if;
  logic                            valid;
  logic                            ready;
  logic [npcm_pkg::IDX_W-1:0]      best_index;
  logic [npcm_pkg::DIST_W-1:0]     best_distance;

  modport source (output valid, best_index, best_distance, input ready);
  modport sink   (input valid, best_index, best_distance, output ready);
endinterface

// ===== hdl/nearest_palette_color_match.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_match
// Maps an RGB pixel to the nearest palette entry by squared distance.
// ----------------------------------------------------------------------------
// Write item: no result; the next item can be taken the next cycle.
// Classify item: n = palette_size clamped to 1..16 entries, read one per cycle; the result
// is valid after the n reads, 2 pipeline stages and 1 result register, and comes later
// while the previous result is still waiting. One item in flight at a time: no new item
// is taken until the result of the last one is published.
// Reset clears control state and sets palette_size to 16; the palette RAM is not cleared.
module nearest_palette_color_match (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [npcm_pkg::SIZE_W-1:0]   cfg_wdata_i,
  npcm_in_if.sink                       item_i,
  npcm_out_if.source                    result_o
);

  logic [npcm_pkg::SIZE_W-1:0] palette_size_q;
  npcm_pkg::npcm_cmd_t         cmd;
  npcm_pkg::npcm_status_t      status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_size_q <= npcm_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      palette_size_q <= cfg_wdata_i;
    end
  end

  npcm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (item_i.valid),
    .in_func_i     (item_i.func),
    .in_ready_o    (item_i.ready),
    .palette_size_i(palette_size_q),
    .cmd_o         (cmd),
    .status_i      (status)
  );

  npcm_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .entry_index_i(item_i.entry_index),
    .red_i        (item_i.red),
    .green_i      (item_i.green),
    .blue_i       (item_i.blue),
    .result_o     (result_o)
  );

endmodule

// ===== hdl/npcm_ram.sv =====
// ----------------------------------------------------------------------------
// npcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module npcm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/npcm_datapath.sv =====
// ----------------------------------------------------------------------------
// npcm_datapath
// Palette RAM, squared-distance pipeline, running minimum and result register.
// ----------------------------------------------------------------------------
module npcm_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  npcm_pkg::npcm_cmd_t           cmd_i,
  output npcm_pkg::npcm_status_t        status_o,
  input  logic [npcm_pkg::IDX_W-1:0]    entry_index_i,
  input  logic [npcm_pkg::COLOR_W-1:0]  red_i,
  input  logic [npcm_pkg::COLOR_W-1:0]  green_i,
  input  logic [npcm_pkg::COLOR_W-1:0]  blue_i,
  npcm_out_if.source                    result_o
);

  logic [npcm_pkg::COLOR_W-1:0] pix_r_q, pix_g_q, pix_b_q;

  // stage 1: RAM read data valid; stage 2: products valid
  logic                         v1_q, v2_q;
  logic [npcm_pkg::ADDR_W-1:0]  idx1_q, idx2_q;
  logic [npcm_pkg::ENTRY_W-1:0] entry;
  logic [npcm_pkg::PROD_W-1:0]  pr_q, pg_q, pb_q;
  logic [npcm_pkg::PROD_W-1:0]  pr_d, pg_d, pb_d;
  logic [npcm_pkg::DIST_W-1:0]  dist_sum;
  logic [npcm_pkg::DIST_W-1:0]  best_q;
  logic [npcm_pkg::ADDR_W-1:0]  best_idx_q;
  logic                         res_valid_q;
  logic [npcm_pkg::IDX_W-1:0]   res_idx_q;
  logic [npcm_pkg::DIST_W-1:0]  res_dist_q;
  logic                         wr_en;

  assign wr_en = cmd_i.wr &&
    ({1'b0, entry_index_i} < (npcm_pkg::IDX_W + 1)'(npcm_pkg::PALETTE_DEPTH));

  npcm_ram #(
    .WIDTH(npcm_pkg::ENTRY_W),
    .DEPTH(npcm_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(entry_index_i[npcm_pkg::ADDR_W-1:0]),
    .wdata_i({red_i, green_i, blue_i}),
    .re_i   (cmd_i.issue),
    .raddr_i(cmd_i.addr),
    .rdata_o(entry)
  );

  function automatic logic [npcm_pkg::PROD_W-1:0] sq_diff(
    input logic [npcm_pkg::COLOR_W-1:0] a,
    input logic [npcm_pkg::COLOR_W-1:0] b
  );
    logic [npcm_pkg::COLOR_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  always_comb begin
    pr_d = sq_diff(pix_r_q, entry[2*npcm_pkg::COLOR_W +: npcm_pkg::COLOR_W]);
    pg_d = sq_diff(pix_g_q, entry[npcm_pkg::COLOR_W +: npcm_pkg::COLOR_W]);
    pb_d = sq_diff(pix_b_q, entry[0 +: npcm_pkg::COLOR_W]);
  end

  assign dist_sum = npcm_pkg::DIST_W'(pr_q) + npcm_pkg::DIST_W'(pg_q)
                  + npcm_pkg::DIST_W'(pb_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pix_r_q <= red_i;
      pix_g_q <= green_i;
      pix_b_q <= blue_i;
    end
    if (cmd_i.issue) begin
      idx1_q <= cmd_i.addr;
    end
    if (v1_q) begin
      pr_q   <= pr_d;
      pg_q   <= pg_d;
      pb_q   <= pb_d;
      idx2_q <= idx1_q;
    end
    // all-ones exceeds any real distance, so the first entry always wins
    if (cmd_i.start) begin
      best_q     <= '1;
      best_idx_q <= '0;
    end else if (v2_q && (dist_sum < best_q)) begin
      best_q     <= dist_sum;
      best_idx_q <= idx2_q;
    end
    if (cmd_i.publish) begin
      res_idx_q  <= npcm_pkg::IDX_W'(best_idx_q);
      res_dist_q <= best_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      if (cmd_i.publish) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.busy     = v1_q || v2_q;
  assign status_o.out_busy = res_valid_q && !result_o.ready;

  assign result_o.valid         = res_valid_q;
  assign result_o.best_index    = res_idx_q;
  assign result_o.best_distance = res_dist_q;

  a_publish_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |-> !v1_q && !v2_q)
    else $error("result published while the pipeline still holds entries");

  a_stage_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |=> v2_q)
    else $error("stage 2 lost an entry from stage 1");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.ready && !cmd_i.publish |=> $stable(res_dist_q))
    else $error("pending result changed");

endmodule

// ===== hdl/npcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// npcm_ctrl
// Sequencer: takes items, steps the palette address and releases the result.
// ----------------------------------------------------------------------------
module npcm_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_func_i,
  output logic                          in_ready_o,
  input  logic [npcm_pkg::SIZE_W-1:0]   palette_size_i,
  output npcm_pkg::npcm_cmd_t           cmd_o,
  input  npcm_pkg::npcm_status_t        status_i
);

  npcm_pkg::state_e            state_q, state_d;
  logic [npcm_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic [npcm_pkg::ADDR_W-1:0] last_addr;
  logic [npcm_pkg::SIZE_W-1:0] size_eff;
  logic                        accept;

  // clamp the searched count to 1..PALETTE_DEPTH
  always_comb begin
    priority if (palette_size_i == '0) begin
      size_eff = npcm_pkg::SIZE_W'(1);
    end else if (palette_size_i > npcm_pkg::SIZE_W'(npcm_pkg::PALETTE_DEPTH)) begin
      size_eff = npcm_pkg::SIZE_W'(npcm_pkg::PALETTE_DEPTH);
    end else begin
      size_eff = palette_size_i;
    end
  end

  assign last_addr = npcm_pkg::ADDR_W'(size_eff - npcm_pkg::SIZE_W'(1));
  assign accept    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= npcm_pkg::S_IDLE;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    addr_d        = addr_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.addr    = addr_q;
    unique case (state_q)
      npcm_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          if (in_func_i == npcm_pkg::FUNC_WRITE) begin
            cmd_o.wr = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            addr_d      = '0;
            state_d     = npcm_pkg::S_SCAN;
          end
        end
      end
      npcm_pkg::S_SCAN: begin
        cmd_o.issue = 1'b1;
        addr_d      = addr_q + npcm_pkg::ADDR_W'(1);
        if (addr_q == last_addr) begin
          state_d = npcm_pkg::S_DRAIN;
        end
      end
      npcm_pkg::S_DRAIN: begin
        // hold until the last entry is compared and the result slot frees up
        if (!status_i.busy && !status_i.out_busy) begin
          cmd_o.publish = 1'b1;
          state_d       = npcm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = npcm_pkg::S_IDLE;
      end
    endcase
  end

  a_start_clears_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> addr_q == '0 && state_q == npcm_pkg::S_SCAN)
    else $error("scan did not begin at entry zero");

  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> addr_q <= last_addr)
    else $error("read issued past the last searched entry");

  a_last_to_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue && addr_q == last_addr |=> state_q == npcm_pkg::S_DRAIN)
    else $error("scan ran past the last entry");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !status_i.busy && !cmd_o.issue)
    else $error("item accepted while a search is in flight");

endmodule
